// ----- rtl/core/cvm_pkg.sv -----
// Shared constants and types for the CORDIC vector magnitude block.
`default_nettype none
package cvm_pkg;

	// Datapath geometry
	localparam int ITERATIONS = 11;
	localparam int WORK_W     = 40;
	localparam int FRAC_BITS  = 8;
	localparam int INPUT_W    = 16;
	localparam int MAG_W      = 16;

	// Inverse CORDIC gain, 0.60725 floored to 15 fraction bits
	localparam int                 INV_GAIN_FRAC = 15;
	localparam logic [INV_GAIN_FRAC-1:0] INV_GAIN = INV_GAIN_FRAC'(19898);

	// Real parts at or above 2**SAT_BITS always saturate
	localparam int SAT_BITS = FRAC_BITS + MAG_W + 1;
	localparam int PROD_W   = SAT_BITS + INV_GAIN_FRAC;
	localparam int QUOT_W   = PROD_W - INV_GAIN_FRAC - FRAC_BITS;

	localparam int SHIFT_W = $clog2(ITERATIONS);

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	typedef logic signed [WORK_W-1:0]  work_t;
	typedef logic signed [INPUT_W-1:0] sample_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [SHIFT_W-1:0]        shift_t;
	typedef logic [PROD_W-1:0]         prod_t;

	// Vector carried from cell to cell
	typedef struct packed {
		work_t x;
		work_t y;
	} vec_t;

endpackage
`default_nettype wire

// ----- rtl/core/cvm_in_if.sv -----
// Input channel carrying one complex sample per transaction.
`default_nettype none
interface cvm_in_if;
	import cvm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t real_part;
	sample_t imag_part;

	modport source (output valid, output real_part, output imag_part, input ready);
	modport sink   (input valid, input real_part, input imag_part, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/cvm_out_if.sv -----
// Output channel carrying one magnitude per transaction.
`default_nettype none
interface cvm_out_if;
	import cvm_pkg::*;

	logic valid;
	logic ready;
	mag_t magnitude;

	modport source (output valid, output magnitude, input ready);
	modport sink   (input valid, input magnitude, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/cordic_vector_magnitude.sv -----
// Top level: magnitude of a complex sample by a pipelined CORDIC vectoring chain.
`default_nettype none
// One sample is accepted every cycle while ready is high, and one magnitude leaves
// per sample, in order. A sample passes one register per rotation cell, one for
// the gain multiplier and one output register. Every stage holds its own valid
// bit, so bubbles are squeezed out and the block keeps taking samples while a
// result waits at the output; ready only drops once every stage is full and the
// output is stalled. There is no quadrant pre-rotation: samples more than about
// 100 degrees from the positive real axis give poor magnitudes, negative results
// read 0 and large ones saturate at 65535.
module cordic_vector_magnitude (
	input  wire       clk,
	input  wire       arst_n,
	cvm_in_if.sink    sample,
	cvm_out_if.source result
);
	import cvm_pkg::*;

	logic [ITERATIONS:0] valid_c;
	logic [ITERATIONS:0] ready_c;
	vec_t                data_c [ITERATIONS+1];

	// Scale inputs onto the fixed-point datapath
	assign valid_c[0]  = sample.valid;
	assign sample.ready = ready_c[0];
	assign data_c[0].x = WORK_W'(sample.real_part) <<< FRAC_BITS;
	assign data_c[0].y = WORK_W'(sample.imag_part) <<< FRAC_BITS;

	// Chain of rotation cells, cell i shifts by i
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		cvm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (SHIFT_W'(i)),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.up_data  (data_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.dn_data  (data_c[i+1])
		);
	end

	// Gain compensation and output register
	cvm_gain u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[ITERATIONS]),
		.up_ready (ready_c[ITERATIONS]),
		.up_x     (data_c[ITERATIONS].x),
		.dn_valid (result.valid),
		.dn_ready (result.ready),
		.dn_mag   (result.magnitude)
	);

endmodule
`default_nettype wire

// ----- rtl/core/cvm_cell.sv -----
// One CORDIC vectoring micro-rotation cell with its own pipeline register.
`default_nettype none
module cvm_cell (
	input  wire              clk,
	input  wire              arst_n,
	input  cvm_pkg::shift_t  shift,
	input  wire              up_valid,
	output logic             up_ready,
	input  cvm_pkg::vec_t    up_data,
	output logic             dn_valid,
	input  wire              dn_ready,
	output cvm_pkg::vec_t    dn_data
);
	import cvm_pkg::*;

	logic  valid_q;
	vec_t  data_q;
	work_t xs;
	work_t ys;
	vec_t  rot;

	// Rotate toward the real axis; zero imaginary counts as non-negative
	always_comb begin
		xs = up_data.x >>> shift;
		ys = up_data.y >>> shift;
		if (up_data.y[WORK_W-1]) begin
			rot.x = up_data.x - ys;
			rot.y = up_data.y + xs;
		end else begin
			rot.x = up_data.x + ys;
			rot.y = up_data.y - xs;
		end
	end

	// Take a new transaction when empty or when the neighbor drains this one
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= rot;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule
`default_nettype wire

// ----- rtl/core/cvm_gain.sv -----
// Gain compensation and saturation: multiply stage, then output register.
`default_nettype none
module cvm_gain (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            up_valid,
	output logic           up_ready,
	input  cvm_pkg::work_t up_x,
	output logic           dn_valid,
	input  wire            dn_ready,
	output cvm_pkg::mag_t  dn_mag
);
	import cvm_pkg::*;

	logic                valid_s1;
	logic                neg_s1;
	logic                big_s1;
	prod_t               prod_s1;
	logic                valid_s2;
	mag_t                mag_s2;
	logic                adv_s2;
	logic [QUOT_W-1:0]   quot;
	mag_t                mag_next;

	// Stage 1: flag sign and overflow, multiply by the inverse gain
	assign adv_s2   = !valid_s2 || dn_ready;
	assign up_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			neg_s1  <= up_x[WORK_W-1];
			big_s1  <= |up_x[WORK_W-2:SAT_BITS];
			prod_s1 <= PROD_W'(up_x[SAT_BITS-1:0]) * PROD_W'(INV_GAIN);
		end
	end

	// Stage 2: drop fraction bits, clamp to the output range
	always_comb begin
		quot = prod_s1[PROD_W-1:INV_GAIN_FRAC+FRAC_BITS];
		if (neg_s1) begin
			mag_next = '0;
		end else if (big_s1 || (quot > QUOT_W'(MAG_MAX))) begin
			mag_next = MAG_MAX;
		end else begin
			mag_next = quot[MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			mag_s2 <= mag_next;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_mag   = mag_s2;

`ifndef ASSERT_OFF
	a_neg_clamps_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && valid_s1 && neg_s1) |=> (valid_s2 && (mag_s2 == '0)))
		else $error("negative real part did not clamp to zero");

	a_big_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && valid_s1 && !neg_s1 && big_s1) |=> (valid_s2 && (mag_s2 == MAG_MAX)))
		else $error("oversized real part did not saturate");

	a_output_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("output became valid without a stage 1 transaction");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the CORDIC vector magnitude pipeline.
`timescale 1ns / 1ps
module tb_top;
	import cvm_pkg::*;

	// Inverse gain in Q15 and the real-part level above which the output always saturates
	localparam longint GAIN_Q15   = 19898;
	localparam int     GAIN_SHIFT = 15;
	localparam longint SAT_LEVEL  = longint'(1) <<< (FRAC_BITS + 17);
	localparam int     CALM_TAIL  = 150;
	localparam int     STALL_LEN  = 90;

	typedef struct {
		sample_t re;
		sample_t im;
	} iq_t;

	typedef struct {
		sample_t re;
		sample_t im;
		mag_t    mag;
	} mag_check_t;

	logic clk;
	logic arst_n;

	cvm_in_if  sample_ch ();
	cvm_out_if result_ch ();

	cordic_vector_magnitude dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	iq_t        pending_samples[$];
	mag_check_t expected_mags[$];
	mag_check_t oldest_mag;
	iq_t        next_sample;
	int         total_items;
	int         taken_cnt;
	int         backlog_hold;
	int         tx_gap;
	int         rx_gap;
	int         mismatches;
	sample_t    corner_vals[5] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};

	// Run the vectoring micro-rotations and the gain correction for one sample
	function automatic mag_t cordic_magnitude(input sample_t re, input sample_t im);
		work_t  x;
		work_t  y;
		work_t  nx;
		work_t  ny;
		longint prod;
		x = work_t'(re) <<< FRAC_BITS;
		y = work_t'(im) <<< FRAC_BITS;
		for (int i = 0; i < ITERATIONS; i++) begin
			if (y < 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
			end
			x = nx;
			y = ny;
		end
		if (x < 0)
			return '0;
		if (longint'(x) >= SAT_LEVEL)
			return MAG_MAX;
		prod = (longint'(x) * GAIN_Q15) >>> (GAIN_SHIFT + FRAC_BITS);
		return (prod > longint'(MAG_MAX)) ? MAG_MAX : mag_t'(prod);
	endfunction

	function automatic void queue_sample(input sample_t re, input sample_t im);
		iq_t s;
		s.re = re;
		s.im = im;
		pending_samples.push_back(s);
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Free-running clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Sender: offer queued samples, idle in random bursts, hold valid until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				expected_mags.push_back('{sample_ch.real_part, sample_ch.imag_part,
					cordic_magnitude(sample_ch.real_part, sample_ch.imag_part)});
			if (!sample_ch.valid || sample_ch.ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					sample_ch.valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					next_sample = pending_samples.pop_front();
					sample_ch.real_part <= next_sample.re;
					sample_ch.imag_part <= next_sample.im;
					sample_ch.valid     <= 1'b1;
					if (taken_cnt < total_items - CALM_TAIL && $urandom_range(0, 9) == 0)
						tx_gap = $urandom_range(1, 13);
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Count accepted samples and hold the output off twice to back up the pipeline
	always @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready && (taken_cnt == 300 || taken_cnt == 700))
			backlog_hold <= STALL_LEN;
		else if (backlog_hold != 0)
			backlog_hold <= backlog_hold - 1;
		if (sample_ch.valid && sample_ch.ready)
			taken_cnt <= taken_cnt + 1;
	end

	// Receiver: check each magnitude against the oldest prediction, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_mags.size() == 0) begin
					report_mismatch($sformatf("magnitude %0d arrived with none expected",
						result_ch.magnitude));
				end else begin
					oldest_mag = expected_mags.pop_front();
					if (result_ch.magnitude !== oldest_mag.mag)
						report_mismatch($sformatf("re %0d im %0d: magnitude %0d, expected %0d",
							oldest_mag.re, oldest_mag.im, result_ch.magnitude, oldest_mag.mag));
				end
			end
			if (rx_gap > 0)
				rx_gap--;
			else if (taken_cnt < total_items - CALM_TAIL && $urandom_range(0, 11) == 0)
				rx_gap = $urandom_range(1, 13);
			result_ch.ready <= (rx_gap == 0) && (backlog_hold == 0);
		end
	end

	// Stimulus, reset and end of run
	initial begin
		sample_ch.valid     = 1'b0;
		sample_ch.real_part = '0;
		sample_ch.imag_part = '0;
		result_ch.ready     = 1'b0;
		arst_n       = 1'b0;
		taken_cnt    = 0;
		backlog_hold = 0;
		tx_gap       = 0;
		rx_gap       = 0;
		mismatches   = 0;

		// Axes, corners, negative real parts and mixed signs
		queue_sample(16'sd0, 16'sd0);
		queue_sample(16'sd1, 16'sd0);
		queue_sample(16'sd32767, 16'sd0);
		queue_sample(16'sd32767, 16'sd32767);
		queue_sample(16'sd32767, -16'sd32768);
		queue_sample(16'sd32767, -16'sd1);
		queue_sample(-16'sd1, -16'sd1);
		queue_sample(-16'sd32768, 16'sd0);
		queue_sample(-16'sd32768, -16'sd32768);
		queue_sample(-16'sd32768, 16'sd32767);
		queue_sample(16'sd0, 16'sd32767);
		queue_sample(16'sd0, -16'sd32768);
		queue_sample(-16'sd1, 16'sd0);
		queue_sample(16'sd0, -16'sd1);
		queue_sample(16'sd1, 16'sd1);
		queue_sample(16'sd21000, -16'sd21000);
		queue_sample(16'sd12345, -16'sd6789);
		queue_sample(-16'sd100, 16'sd5);
		queue_sample(16'sd100, -16'sd32768);
		queue_sample(16'sd30000, 16'sd20000);

		// Random samples: full range, right half-plane, small, on an axis, corners
		repeat (1130) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: queue_sample(sample_t'($urandom), sample_t'($urandom));
				5, 6: queue_sample(sample_t'($urandom_range(0, 32767)), sample_t'($urandom));
				7: queue_sample(sample_t'(int'($urandom_range(0, 64)) - 32),
					sample_t'(int'($urandom_range(0, 64)) - 32));
				8: begin
					if ($urandom_range(0, 1))
						queue_sample(sample_t'($urandom), 16'sd0);
					else
						queue_sample(16'sd0, sample_t'($urandom));
				end
				default: queue_sample(corner_vals[$urandom_range(0, 4)],
					corner_vals[$urandom_range(0, 4)]);
			endcase
		end
		total_items = pending_samples.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all samples taken, every magnitude back, then watch for strays
		wait (pending_samples.size() == 0 && !sample_ch.valid);
		wait (expected_mags.size() == 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_mags.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#(20 * 400_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
